// ===== sv/dltq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dltq_pkg;

  // sizing
  localparam int TIMER_SLOTS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ID_W        = 8;
  localparam int DELTA_W     = 24;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // operation codes
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // result kinds
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_REFUSED = 1'b1;

  // input word
  typedef struct packed {
    logic [1:0]         operation;
    logic [ID_W-1:0]    timer_id;
    logic [DELTA_W-1:0] duration;
  } in_word_t;

  // result word
  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] expired_id;
    logic            last;
  } out_word_t;

  // one slot of the chain, time held as cumulative remaining milliseconds
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    ident;
    logic [DELTA_W-1:0] cum;
  } slot_t;

  // per-cycle command to all cells
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_POP,
    CMD_DEC
  } cell_cmd_t;

  // control broadcast from the sequencer to the cells
  typedef struct packed {
    cell_cmd_t          cmd;
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] dur;
    logic               head_ge;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXPIRE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/dltq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dltq_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dltq_pkg::cell_ctl_t ctl,
  input  wire dltq_pkg::slot_t   left_slot,
  input  wire logic              left_ge,
  input  wire dltq_pkg::slot_t   right_slot,
  input  wire logic              seen_in,
  output dltq_pkg::slot_t        slot_q,
  output logic                   ge,
  output logic                   seen_out
);
  import dltq_pkg::*;

  slot_t slot_r;
  slot_t slot_nxt;
  logic  match;
  logic  open_here;

  // insert point: later entries move right; all do if head cum >= dur
  assign ge        = slot_r.valid && ((slot_r.cum > ctl.dur) || ctl.head_ge);
  assign open_here = ge || !slot_r.valid;

  // first id match and everything after it moves left on cancel
  assign match    = slot_r.valid && (slot_r.ident == ctl.id);
  assign seen_out = seen_in || match;

  // next slot contents
  always_comb begin
    slot_nxt = slot_r;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (open_here && left_ge) begin
          slot_nxt = left_slot;
        end else if (open_here && left_slot.valid) begin
          slot_nxt.valid = 1'b1;
          slot_nxt.ident = ctl.id;
          slot_nxt.cum   = ctl.dur;
        end
      end
      CMD_REMOVE: begin
        if (seen_out) begin
          slot_nxt = right_slot;
        end
      end
      CMD_POP: begin
        slot_nxt = right_slot;
      end
      CMD_DEC: begin
        if (slot_r.valid) begin
          slot_nxt.cum = slot_r.cum - DELTA_W'(1);
        end
      end
      default: begin
        slot_nxt = slot_r;
      end
    endcase
  end

  // slot register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_q = slot_r;

endmodule
`default_nettype wire

// ===== sv/delta_list_timer_queue_unit.sv =====
// channel | ports                                  | word
// --------+----------------------------------------+------------------------------------
// input   | in_valid, in_ready, in_data            | operation, timer_id, duration
// result  | out_valid, out_ready, out_data         | kind, expired_id, last
//
// set and cancel act on the cell chain directly; a tick on a non-empty chain
// decrements it unless the head has already expired, then expiries leave the
// head cell one at a time as the chain shifts left (at most MAX_RESULTS per tick).
// a tick on an empty chain leaves the chain unchanged.
// rst_n is synchronous: it empties the chain and the result register.
// a stalled result register holds the chain and blocks new words.
`timescale 1ns / 1ps
`default_nettype none
module delta_list_timer_queue_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dltq_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dltq_pkg::out_word_t      out_data
);
  import dltq_pkg::*;

  state_t               state_r;
  state_t               state_nxt;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     n_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  out_word_t            out_word_r;
  out_word_t            out_word_nxt;
  cell_ctl_t            ctl;

  slot_t                slots   [TIMER_SLOTS];
  logic                 ge_vec  [TIMER_SLOTS];
  logic                 seen_vec[TIMER_SLOTS];
  slot_t                left_s  [TIMER_SLOTS];
  logic                 left_g  [TIMER_SLOTS];
  slot_t                right_s [TIMER_SLOTS];
  logic                 seen_i  [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] valid_vec;

  logic in_fire;
  logic can_emit;
  logic more;
  logic emit;
  logic last_flag;
  logic full;

  // the cell chain
  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_s[i] = '{valid: 1'b1, ident: '0, cum: '0};
      assign left_g[i] = 1'b0;
      assign seen_i[i] = 1'b0;
    end else begin : g_mid
      assign left_s[i] = slots[i-1];
      assign left_g[i] = ge_vec[i-1];
      assign seen_i[i] = seen_vec[i-1];
    end
    if (i == TIMER_SLOTS - 1) begin : g_last
      assign right_s[i] = '{valid: 1'b0, ident: '0, cum: '0};
    end else begin : g_inner
      assign right_s[i] = slots[i+1];
    end
    assign valid_vec[i] = slots[i].valid;

    dltq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_slot  (left_s[i]),
      .left_ge    (left_g[i]),
      .right_slot (right_s[i]),
      .seen_in    (seen_i[i]),
      .slot_q     (slots[i]),
      .ge         (ge_vec[i]),
      .seen_out   (seen_vec[i])
    );
  end

  // handshake and status
  assign can_emit  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && can_emit;
  assign in_fire   = in_valid && in_ready;
  assign full      = slots[TIMER_SLOTS-1].valid;
  assign more      = slots[0].valid && (slots[0].cum == '0);
  assign emit      = (state_r == ST_EXPIRE) && more && can_emit;
  assign last_flag = !(slots[1].valid && (slots[1].cum == '0)) ||
                     (n_r == CNT_W'(MAX_RESULTS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.operation == OP_TICK) && slots[0].valid) begin
          state_nxt = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (!more || (emit && last_flag)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // cell commands
  always_comb begin
    ctl.cmd     = CMD_HOLD;
    ctl.id      = in_data.timer_id;
    ctl.dur     = in_data.duration;
    ctl.head_ge = slots[0].valid && (slots[0].cum >= in_data.duration);
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.operation)
            OP_SET: begin
              if ((in_data.duration != '0) && !full) begin
                ctl.cmd = CMD_INSERT;
              end
            end
            OP_CANCEL: begin
              ctl.cmd = CMD_REMOVE;
            end
            OP_TICK: begin
              if (slots[0].valid && (slots[0].cum != '0)) begin
                ctl.cmd = CMD_DEC;
              end
            end
            default: begin
              ctl.cmd = CMD_HOLD;
            end
          endcase
        end
      end
      ST_EXPIRE: begin
        if (emit) begin
          ctl.cmd = CMD_POP;
        end
      end
      default: begin
        ctl.cmd = CMD_HOLD;
      end
    endcase
  end

  // result register and expiry count
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    n_nxt         = n_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '{kind: KIND_EXPIRED, expired_id: slots[0].ident, last: last_flag};
      n_nxt         = n_r + CNT_W'(1);
    end else if (in_fire && (in_data.operation == OP_SET)) begin
      if (in_data.duration == '0) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{kind: KIND_EXPIRED, expired_id: in_data.timer_id, last: 1'b1};
      end else if (full) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{kind: KIND_REFUSED, expired_id: in_data.timer_id, last: 1'b1};
      end
    end
    if (in_fire) begin
      n_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // occupied cells always form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + TIMER_SLOTS'(1))) == '0)
    else $error("occupied cells are not contiguous from the head");

  // head never expires later than the second entry
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    slots[1].valid |-> (slots[0].cum <= slots[1].cum))
    else $error("chain out of expiry order");

  // a stored set grows the chain by exactly one
  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.operation == OP_SET) && (in_data.duration != '0) && !full)
    |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
    else $error("set did not add one entry");

  // a cancel removes at most one entry
  a_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.operation == OP_CANCEL))
    |=> (($countones(valid_vec) == $past($countones(valid_vec))) ||
         ($countones(valid_vec) + 1 == $past($countones(valid_vec)))))
    else $error("cancel removed more than one entry");

endmodule
`default_nettype wire
